FILE: rtl/pmhb_pkg.sv
// pmhb_pkg: shared constants, codes, types and the arctangent table for the
// polar max-height binning unit
// depends on nothing
package pmhb_pkg;

  localparam int MAX_RINGS_DEF     = 32;
  localparam int MAX_SECTORS_DEF   = 64;
  localparam int COORD_BITS_DEF    = 24;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int CELL_W        = 24;
  localparam int RADIUS_W      = 23;
  localparam int RING_CNT_W    = 6;
  localparam int SECTOR_CNT_W  = 7;
  localparam int CNT_W         = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_W         = 23;
  localparam int ACTION_W      = 2;
  localparam int STATUS_W      = 3;
  localparam int READ_RING_W   = 5;
  localparam int READ_SECTOR_W = 6;
  localparam int ANGLE_W       = 32;
  localparam int STEP_W        = 5;
  localparam int CORDIC_STEPS  = 30;
  localparam int HEIGHT_W      = 40;

  localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};

  localparam logic [RADIUS_W-1:0]     MAX_RADIUS_RST   = 23'd20480;
  localparam logic [RING_CNT_W-1:0]   RING_COUNT_RST   = 6'd20;
  localparam logic [SECTOR_CNT_W-1:0] SECTOR_COUNT_RST = 7'd60;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT = 2'd2;

  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_BINNED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_READ     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 3'd4;

  typedef enum logic [1:0] {GOP_READ, GOP_UPDATE, GOP_CLEAR} grid_op_t;

  typedef struct packed {
    logic     valid;
    grid_op_t op;
  } grid_req_t;

  typedef struct packed {
    logic done;
    logic ready;
  } grid_resp_t;

  typedef enum logic [2:0] {TP_INIT, TP_IDLE, TP_LOCATE, TP_GRID, TP_RESULT} top_state_t;
  typedef enum logic [1:0] {GR_SWEEP, GR_IDLE, GR_WAIT} grid_state_t;
  typedef enum logic [2:0] {
    RG_IDLE, RG_SQX, RG_SQY, RG_SUM, RG_CHECK, RG_LHS, RG_MUL, RG_CMP
  } ring_state_t;
  typedef enum logic [1:0] {CD_IDLE, CD_ITER, CD_MUL, CD_SECT} cordic_state_t;

  function automatic logic [ANGLE_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [ANGLE_W-1:0] t;
    unique case (i)
      5'd0:    t = 32'h20000000;
      5'd1:    t = 32'h12E4051E;
      5'd2:    t = 32'h09FB385B;
      5'd3:    t = 32'h051111D4;
      5'd4:    t = 32'h028B0D43;
      5'd5:    t = 32'h0145D7E1;
      5'd6:    t = 32'h00A2F61E;
      5'd7:    t = 32'h00517C55;
      5'd8:    t = 32'h0028BE53;
      5'd9:    t = 32'h00145F2F;
      5'd10:   t = 32'h000A2F98;
      5'd11:   t = 32'h000517CC;
      5'd12:   t = 32'h00028BE6;
      5'd13:   t = 32'h000145F3;
      5'd14:   t = 32'h0000A2FA;
      5'd15:   t = 32'h0000517D;
      5'd16:   t = 32'h000028BE;
      5'd17:   t = 32'h0000145F;
      5'd18:   t = 32'h00000A30;
      5'd19:   t = 32'h00000518;
      5'd20:   t = 32'h0000028C;
      5'd21:   t = 32'h00000146;
      5'd22:   t = 32'h000000A3;
      5'd23:   t = 32'h00000051;
      5'd24:   t = 32'h00000029;
      5'd25:   t = 32'h00000014;
      5'd26:   t = 32'h0000000A;
      5'd27:   t = 32'h00000005;
      5'd28:   t = 32'h00000003;
      5'd29:   t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/pmhb_ring.sv
// pmhb_ring: planar range check and ring search
// depends on pmhb_pkg
module pmhb_ring import pmhb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  input  logic [RADIUS_W-1:0]          radius,
  input  logic [CNT_W-1:0]             ring_n,
  output logic                         done,
  output logic                         in_range,
  output logic [CNT_W-1:0]             ring
);

  localparam int SQ_IN_W = 2 * COORD_BITS;
  localparam int SW      = SQ_IN_W + 1;
  localparam int RSQ_W   = 2 * RADIUS_W;
  localparam int LHS1_W  = RSQ_W + CNT_W;
  localparam int LHS_W   = LHS1_W + CNT_W;
  localparam int ACC_W   = RADIUS_W + CNT_W;
  localparam int SQK_W   = 2 * ACC_W;

  ring_state_t state, state_next;

  logic [COORD_BITS-1:0] ax, ay;
  logic [RADIUS_W-1:0]   r;
  logic [CNT_W-1:0]      n, k;
  logic [SQ_IN_W-1:0]    sx, sy;
  logic [SW-1:0]         s;
  logic [RSQ_W-1:0]      rsq;
  logic [RSQ_W-1:0]      s_lo;
  logic [LHS1_W-1:0]     lhs1;
  logic [LHS_W-1:0]      lhs;
  logic [ACC_W-1:0]      acc;
  logic [SQK_W-1:0]      sqk;
  logic                  outside, hit, last;

  assign s_lo    = RSQ_W'(s);
  assign outside = (s > SW'(rsq)) || ((SW > RSQ_W) && (s >> RSQ_W) != '0);
  assign hit     = (SQK_W'(sqk) >= lhs);
  assign last    = ((k + 1'b1) == n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      RG_IDLE:  if (start) state_next = RG_SQX;
      RG_SQX:   state_next = RG_SQY;
      RG_SQY:   state_next = RG_SUM;
      RG_SUM:   state_next = RG_CHECK;
      RG_CHECK: state_next = outside ? RG_IDLE : RG_LHS;
      RG_LHS:   state_next = RG_MUL;
      RG_MUL:   state_next = RG_CMP;
      RG_CMP:   state_next = (hit || last) ? RG_IDLE : RG_MUL;
      default:  state_next = RG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == RG_CHECK) && outside) || ((state == RG_CMP) && (hit || last));
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      RG_IDLE: begin
        if (start) begin
          ax <= x_in[COORD_BITS-1] ? COORD_BITS'(-x_in) : COORD_BITS'(x_in);
          ay <= y_in[COORD_BITS-1] ? COORD_BITS'(-y_in) : COORD_BITS'(y_in);
          r  <= (radius == '0) ? RADIUS_W'(1) : radius;
          n  <= ring_n;
        end
      end
      RG_SQX: begin
        sx  <= SQ_IN_W'(ax) * SQ_IN_W'(ax);
        rsq <= RSQ_W'(r) * RSQ_W'(r);
      end
      RG_SQY: sy <= SQ_IN_W'(ay) * SQ_IN_W'(ay);
      RG_SUM: s <= SW'(sx) + SW'(sy);
      RG_CHECK: begin
        in_range <= !outside;
        ring     <= '0;
        lhs1     <= LHS1_W'(s_lo) * LHS1_W'(n);
      end
      RG_LHS: begin
        lhs <= LHS_W'(lhs1) * LHS_W'(n);
        k   <= '0;
        acc <= '0;
      end
      RG_MUL: sqk <= SQK_W'(acc) * SQK_W'(acc);
      RG_CMP: begin
        if (hit) begin
          ring <= (k == '0) ? '0 : k - 1'b1;
        end else if (last) begin
          ring <= n - 1'b1;
        end else begin
          k   <= k + 1'b1;
          acc <= acc + ACC_W'(r);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/pmhb_cordic.sv
// pmhb_cordic: vectoring cordic for the binary angle and the sector index
// depends on pmhb_pkg
module pmhb_cordic import pmhb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  input  logic [CNT_W-1:0]             sector_n,
  output logic                         done,
  output logic [CNT_W-1:0]             sector
);

  localparam int CW     = COORD_BITS + 19;
  localparam int PROD_W = 16 + CNT_W;
  localparam int Q_W    = PROD_W + 1;

  cordic_state_t state, state_next;

  logic signed [CW-1:0] cx, cy, xe, ye, dx, dy;
  logic [ANGLE_W-1:0]   ang, ang_rnd;
  logic [STEP_W-1:0]    i;
  logic [CNT_W-1:0]     n;
  logic [PROD_W-1:0]    prod;
  logic [Q_W-1:0]       q_sum;
  logic [Q_W-17:0]      q;
  logic                 origin, neg, last;

  assign xe      = CW'(x_in);
  assign ye      = CW'(y_in);
  assign origin  = (x_in == '0) && (y_in == '0);
  assign neg     = x_in[COORD_BITS-1];
  assign dx      = cy >>> i;
  assign dy      = cx >>> i;
  assign last    = (i == STEP_W'(CORDIC_STEPS - 1));
  assign ang_rnd = ang + 32'h0000_8000;
  assign q_sum   = Q_W'(prod) + Q_W'(16'hFFFF);
  assign q       = q_sum[Q_W-1:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CD_IDLE: if (start) state_next = origin ? CD_MUL : CD_ITER;
      CD_ITER: if (last) state_next = CD_MUL;
      CD_MUL:  state_next = CD_SECT;
      CD_SECT: state_next = CD_IDLE;
      default: state_next = CD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == CD_SECT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      CD_IDLE: begin
        if (start) begin
          cx  <= (neg ? -xe : xe) <<< 16;
          cy  <= (neg ? -ye : ye) <<< 16;
          ang <= (neg && !origin) ? 32'h8000_0000 : '0;
          i   <= '0;
          n   <= sector_n;
        end
      end
      CD_ITER: begin
        if (!cy[CW-1]) begin
          cx  <= cx + dx;
          cy  <= cy - dy;
          ang <= ang + atan_entry(i);
        end else begin
          cx  <= cx - dx;
          cy  <= cy + dy;
          ang <= ang - atan_entry(i);
        end
        i <= i + 1'b1;
      end
      CD_MUL: prod <= PROD_W'(ang_rnd[31:16]) * PROD_W'(n);
      CD_SECT: begin
        if (q == '0) begin
          sector <= '0;
        end else if (q > (Q_W-16)'(n)) begin
          sector <= n - 1'b1;
        end else begin
          sector <= CNT_W'(q - 1'b1);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/pmhb_grid.sv
// pmhb_grid: height grid memory with read-modify-write and clearing sweep
// depends on pmhb_pkg
module pmhb_grid import pmhb_pkg::*; #(
  parameter int DEPTH = MAX_RINGS_DEF * MAX_SECTORS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  grid_req_t         req,
  input  logic [AW-1:0]     addr,
  input  logic [CELL_W-1:0] value,
  output grid_resp_t        resp,
  output logic [CELL_W-1:0] data
);

  grid_state_t state, state_next;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data, merged;
  logic [AW-1:0]     cnt, addr_q, waddr;
  logic [CELL_W-1:0] val_q, wdata;
  grid_op_t          op_q;
  logic              we, done, done_next, sweep_last;

  assign sweep_last = (cnt == AW'(DEPTH - 1));
  assign merged     = (val_q > rd_data) ? val_q : rd_data;
  assign resp       = '{done: done, ready: (state == GR_IDLE)};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= GR_SWEEP;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == GR_SWEEP) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == GR_IDLE && req.valid) begin
      addr_q <= addr;
      val_q  <= value;
      op_q   <= req.op;
    end
    if (state == GR_WAIT) begin
      data <= (op_q == GOP_UPDATE) ? merged : rd_data;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = addr_q;
    wdata      = merged;
    done_next  = 1'b0;
    unique case (state)
      GR_SWEEP: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = '0;
        if (sweep_last) begin
          state_next = GR_IDLE;
          done_next  = 1'b1;
        end
      end
      GR_IDLE: begin
        if (req.valid) begin
          state_next = (req.op == GOP_CLEAR) ? GR_SWEEP : GR_WAIT;
        end
      end
      GR_WAIT: begin
        we         = (op_q == GOP_UPDATE);
        done_next  = 1'b1;
        state_next = GR_IDLE;
      end
      default: state_next = GR_IDLE;
    endcase
  end

endmodule

FILE: rtl/polar_max_height_binning_unit.sv
// polar_max_height_binning_unit: top level, configuration registers, control
// depends on pmhb_pkg, pmhb_ring, pmhb_cordic, pmhb_grid
//
// One word is handled at a time: in_stall stays high from acceptance until the
// result has moved into the output register, and a finished result waits there
// while the next word is taken. An add in range runs the 30-step cordic and the
// sector scaling beside the ring search, waits for whichever ends later, then
// hands over to the grid read-modify-write; the ring search runs longer for outer
// rings. A point out of range also waits for both, then skips the grid; a read
// uses the grid read only, and a bad address or unknown action goes straight to
// the result. The next word can be taken once the result has moved into the output
// register, later while out_stall holds an earlier result there. A clear, and the
// pass after reset, sweep all MAX_RINGS*MAX_SECTORS grid cells (2048 by default),
// one cell a cycle; a clear gives its result after the sweep and no word is taken
// meanwhile.
module polar_max_height_binning_unit import pmhb_pkg::*; #(
  parameter int MAX_RINGS     = MAX_RINGS_DEF,
  parameter int MAX_SECTORS   = MAX_SECTORS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ACTION_W-1:0]          action,
  input  logic signed [COORD_BITS-1:0] x_pos,
  input  logic signed [COORD_BITS-1:0] y_pos,
  input  logic signed [COORD_BITS-1:0] z_pos,
  input  logic [READ_RING_W-1:0]       read_ring,
  input  logic [READ_SECTOR_W-1:0]     read_sector,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [STATUS_W-1:0]          status,
  output logic [CELL_W-1:0]            cell_value,
  output logic [READ_RING_W-1:0]       bin_ring,
  output logic [READ_SECTOR_W-1:0]     bin_sector
);

  localparam int DEPTH = MAX_RINGS * MAX_SECTORS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  top_state_t state, state_next;

  logic [RADIUS_W-1:0]     range_limit;
  logic [RING_CNT_W-1:0]   ring_count;
  logic [SECTOR_CNT_W-1:0] sector_count;
  logic [CNT_W-1:0]        nr, ns;

  logic [ACTION_W-1:0]         action_q;
  logic signed [COORD_BITS-1:0] z_q;
  logic [READ_RING_W-1:0]      rr_q;
  logic [READ_SECTOR_W-1:0]    rs_q;

  logic [STATUS_W-1:0]      res_status;
  logic [CELL_W-1:0]        res_value;
  logic [READ_RING_W-1:0]   res_ring;
  logic [READ_SECTOR_W-1:0] res_sector;

  logic accept, start, read_ok, ring_seen, sect_seen, out_free, load_out;
  logic ring_done, ring_in, sect_done;
  logic [CNT_W-1:0] ring_sel, sect_idx;

  grid_req_t         greq;
  grid_resp_t        gresp;
  logic [AW-1:0]     gaddr;
  logic [CELL_W-1:0] gvalue, gdata;

  logic signed [HEIGHT_W-1:0] height;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign start     = accept && (action == ACT_ADD);
  assign out_free  = !out_valid || !out_stall;
  assign load_out  = (state == TP_RESULT) && out_free;

  assign nr = (ring_count == '0) ? CNT_W'(1) :
              (32'(ring_count) > MAX_RINGS) ? CNT_W'(MAX_RINGS) : CNT_W'(ring_count);
  assign ns = (sector_count == '0) ? CNT_W'(1) :
              (32'(sector_count) > MAX_SECTORS) ? CNT_W'(MAX_SECTORS) : CNT_W'(sector_count);

  assign read_ok = (CNT_W'(read_ring) < nr) && (CNT_W'(read_sector) < ns);

  assign height = HEIGHT_W'(z_q) + (HEIGHT_W'(1) <<< FRACTION_BITS);
  assign gvalue = (height <= 0) ? '0 :
                  (height > $signed(HEIGHT_W'(CELL_MAX))) ? CELL_MAX : CELL_W'(height);

  pmhb_ring #(.COORD_BITS(COORD_BITS)) u_ring (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .x_in     (x_pos),
    .y_in     (y_pos),
    .radius   (range_limit),
    .ring_n   (nr),
    .done     (ring_done),
    .in_range (ring_in),
    .ring     (ring_sel)
  );

  pmhb_cordic #(.COORD_BITS(COORD_BITS)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .x_in     (x_pos),
    .y_in     (y_pos),
    .sector_n (ns),
    .done     (sect_done),
    .sector   (sect_idx)
  );

  pmhb_grid #(.DEPTH(DEPTH), .AW(AW)) u_grid (
    .clk   (clk),
    .rst   (rst),
    .req   (greq),
    .addr  (gaddr),
    .value (gvalue),
    .resp  (gresp),
    .data  (gdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit  <= MAX_RADIUS_RST;
      ring_count   <= RING_COUNT_RST;
      sector_count <= SECTOR_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_RADIUS:   range_limit  <= cfg_data[RADIUS_W-1:0];
        CFG_RING_COUNT:   ring_count   <= cfg_data[RING_CNT_W-1:0];
        CFG_SECTOR_COUNT: sector_count <= cfg_data[SECTOR_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= TP_INIT;
      out_valid <= 1'b0;
      ring_seen <= 1'b0;
      sect_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        ring_seen <= 1'b0;
        sect_seen <= 1'b0;
      end else begin
        if (ring_done) ring_seen <= 1'b1;
        if (sect_done) sect_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_q   <= action;
      z_q        <= z_pos;
      rr_q       <= read_ring;
      rs_q       <= read_sector;
      res_status <= ST_BAD_ADDR;
      res_value  <= '0;
      res_ring   <= (action == ACT_READ) ? read_ring : '0;
      res_sector <= (action == ACT_READ) ? read_sector : '0;
    end
    if (state == TP_LOCATE && ring_seen && sect_seen && !ring_in) begin
      res_status <= ST_OUTSIDE;
    end
    if (state == TP_GRID && gresp.done) begin
      unique case (action_q)
        ACT_ADD: begin
          res_status <= ST_BINNED;
          res_value  <= gdata;
          res_ring   <= READ_RING_W'(ring_sel);
          res_sector <= READ_SECTOR_W'(sect_idx);
        end
        ACT_READ: begin
          res_status <= ST_READ;
          res_value  <= gdata;
          res_ring   <= rr_q;
          res_sector <= rs_q;
        end
        default: res_status <= ST_CLEARED;
      endcase
    end
    if (load_out) begin
      status     <= res_status;
      cell_value <= res_value;
      bin_ring   <= res_ring;
      bin_sector <= res_sector;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != TP_IDLE);
    greq.valid = 1'b0;
    greq.op    = GOP_READ;
    gaddr      = AW'(32'(read_ring) * MAX_SECTORS + 32'(read_sector));
    unique case (state)
      TP_INIT: begin
        if (gresp.ready) state_next = TP_IDLE;
      end
      TP_IDLE: begin
        if (accept) begin
          priority case (action)
            ACT_ADD: state_next = TP_LOCATE;
            ACT_READ: begin
              if (read_ok) begin
                greq.valid = 1'b1;
                state_next = TP_GRID;
              end else begin
                state_next = TP_RESULT;
              end
            end
            ACT_CLEAR: begin
              greq.valid = 1'b1;
              greq.op    = GOP_CLEAR;
              state_next = TP_GRID;
            end
            default: state_next = TP_RESULT;
          endcase
        end
      end
      TP_LOCATE: begin
        gaddr = AW'(32'(ring_sel) * MAX_SECTORS + 32'(sect_idx));
        if (ring_seen && sect_seen) begin
          if (ring_in) begin
            greq.valid = 1'b1;
            greq.op    = GOP_UPDATE;
            state_next = TP_GRID;
          end else begin
            state_next = TP_RESULT;
          end
        end
      end
      TP_GRID: begin
        if (gresp.done) state_next = TP_RESULT;
      end
      TP_RESULT: begin
        if (out_free) state_next = TP_IDLE;
      end
      default: state_next = TP_INIT;
    endcase
  end

endmodule

FILE: sim/pmhb_checker.sv
// pmhb_checker: watches the register, point and result channels of the polar
// max-height binning unit, predicts every result and compares it
// depends on pmhb_pkg
module pmhb_checker import pmhb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [ACTION_W-1:0]        action,
  input  logic signed [23:0]         x_pos,
  input  logic signed [23:0]         y_pos,
  input  logic signed [23:0]         z_pos,
  input  logic [READ_RING_W-1:0]     read_ring,
  input  logic [READ_SECTOR_W-1:0]   read_sector,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [STATUS_W-1:0]        status,
  input  logic [CELL_W-1:0]          cell_value,
  input  logic [READ_RING_W-1:0]     bin_ring,
  input  logic [READ_SECTOR_W-1:0]   bin_sector,
  output int                         fails,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RINGS   = 32;
  localparam int SECTORS = 64;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic [CELL_W-1:0]        value;
    logic [READ_RING_W-1:0]   ring;
    logic [READ_SECTOR_W-1:0] sector;
  } bin_result_t;

  localparam bit [31:0] ARCTAN [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  bit [23:0]   height_cells [RINGS*SECTORS];
  bit [22:0]   radius_limit;
  bit [5:0]    rings_reg;
  bit [6:0]    sectors_reg;
  bin_result_t pending_results [$];

  function automatic bit [15:0] point_angle(longint px, longint py);
    longint dx, dy;
    bit [31:0] acc;
    bit [31:0] rounded;
    acc = 0;
    if (px == 0 && py == 0) return 16'd0;
    if (px < 0) begin
      px = -px;
      py = -py;
      acc = 32'h80000000;
    end
    px = px * 65536;
    py = py * 65536;
    for (int i = 0; i < 30; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py >= 0) begin
        px = px + dx;
        py = py - dy;
        acc = acc + ARCTAN[i];
      end else begin
        px = px - dx;
        py = py + dy;
        acc = acc - ARCTAN[i];
      end
    end
    rounded = acc + 32'd32768;
    return rounded[31:16];
  endfunction

  function automatic int clamp_bin(bit [63:0] k, int n);
    if (k > n) k = n;
    if (k < 1) k = 1;
    return int'(k) - 1;
  endfunction

  function automatic bin_result_t bin_word(logic [ACTION_W-1:0] act, longint px,
                                           longint py, longint pz,
                                           int rr, int rs);
    bin_result_t res;
    int nr, ns, ring, sector, idx;
    bit [63:0] r, s, lhs, k;
    longint v;
    nr = rings_reg;
    ns = sectors_reg;
    if (nr < 1) nr = 1;
    if (nr > RINGS) nr = RINGS;
    if (ns < 1) ns = 1;
    if (ns > SECTORS) ns = SECTORS;
    res = '{ST_BAD_ADDR, '0, '0, '0};
    if (act == ACT_ADD) begin
      r = (radius_limit == 0) ? 64'd1 : 64'(radius_limit);
      s = 64'(px * px) + 64'(py * py);
      if (s > r * r) begin
        res.status = ST_OUTSIDE;
        return res;
      end
      lhs = s * nr * nr;
      for (k = 0; k < nr; k++)
        if ((k * r) * (k * r) >= lhs) break;
      ring = clamp_bin(k, nr);
      sector = clamp_bin((64'(point_angle(px, py)) * ns + 64'd65535) >> 16, ns);
      idx = ring * SECTORS + sector;
      v = pz + 256;
      if (v > longint'(CELL_MAX)) v = longint'(CELL_MAX);
      if (longint'(height_cells[idx]) < v) height_cells[idx] = v[23:0];
      res = '{ST_BINNED, height_cells[idx], ring[4:0], sector[5:0]};
    end else if (act == ACT_READ) begin
      res.ring = rr[4:0];
      res.sector = rs[5:0];
      if (rr < nr && rs < ns) begin
        res.status = ST_READ;
        res.value = height_cells[rr*SECTORS+rs];
      end
    end else if (act == ACT_CLEAR) begin
      foreach (height_cells[i]) height_cells[i] = '0;
      res.status = ST_CLEARED;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("%0t mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    bin_result_t want;
    if (rst) begin
      foreach (height_cells[i]) height_cells[i] = '0;
      radius_limit = MAX_RADIUS_RST;
      rings_reg = RING_COUNT_RST;
      sectors_reg = SECTOR_COUNT_RST;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_RADIUS:   radius_limit = cfg_data[22:0];
          CFG_RING_COUNT:   rings_reg = cfg_data[5:0];
          CFG_SECTOR_COUNT: sectors_reg = cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result words", 0, 1);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) report_mismatch("status", want.status, status);
          if (cell_value !== want.value) report_mismatch("cell_value", want.value, cell_value);
          if (bin_ring !== want.ring) report_mismatch("bin_ring", want.ring, bin_ring);
          if (bin_sector !== want.sector)
            report_mismatch("bin_sector", want.sector, bin_sector);
        end
      end
      if (in_valid && !in_stall)
        pending_results.insert(pending_results.size(),
                               bin_word(action, longint'(x_pos), longint'(y_pos),
                                        longint'(z_pos), read_ring, read_sector));
      outstanding <= pending_results.size();
    end
  end
endmodule

FILE: sim/tb_polar_max_height_binning_unit.sv
// tb_polar_max_height_binning_unit: drives points, reads, clears and register
// writes into the binning unit under several idle patterns and gives the verdict
// depends on pmhb_pkg, pmhb_checker and polar_max_height_binning_unit
module tb_polar_max_height_binning_unit import pmhb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int WORDS_PER_PHASE = 240;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_RADIUS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACTION_W-1:0] action = ACT_ADD;
  logic signed [23:0] x_pos = '0;
  logic signed [23:0] y_pos = '0;
  logic signed [23:0] z_pos = '0;
  logic [READ_RING_W-1:0] read_ring = '0;
  logic [READ_SECTOR_W-1:0] read_sector = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [CELL_W-1:0] cell_value;
  logic [READ_RING_W-1:0] bin_ring;
  logic [READ_SECTOR_W-1:0] bin_sector;

  int fails;
  int outstanding;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int radius_now = 20480;

  polar_max_height_binning_unit u_top (.*);

  pmhb_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(logic [ACTION_W-1:0] act, int px, int py, int pz,
                           int rr, int rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    action <= act;
    x_pos <= px[23:0];
    y_pos <= py[23:0];
    z_pos <= pz[23:0];
    read_ring <= rr[4:0];
    read_sector <= rs[5:0];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_index <= idx;
    cfg_data <= value[22:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_grid(int radius, int rings, int sectors);
    wait_drained();
    repeat (60) @(posedge clk);
    write_reg(CFG_MAX_RADIUS, radius);
    write_reg(CFG_RING_COUNT, rings);
    write_reg(CFG_SECTOR_COUNT, sectors);
    cfg_valid <= 1'b0;
    radius_now = (radius == 0) ? 1 : radius;
  endtask

  function automatic int near_coord(int bound);
    return int'($urandom_range(2 * bound)) - bound;
  endfunction

  task automatic random_word();
    int pick, bound, px, py;
    pick = $urandom_range(99);
    bound = radius_now / int'($urandom_range(1, 2));
    if ($urandom_range(3) == 0) begin
      px = int'($urandom);
      py = int'($urandom);
    end else begin
      px = near_coord(bound);
      py = near_coord(bound);
    end
    if (pick < 70)
      send_word(ACT_ADD, px, py, int'($urandom), 0, 0);
    else if (pick < 92)
      send_word(ACT_READ, 0, 0, 0, $urandom_range(31), $urandom_range(63));
    else if (pick < 94)
      send_word(ACT_CLEAR, px, py, 0, 0, 0);
    else
      send_word(ACT_UNUSED, px, py, int'($urandom), $urandom_range(31), $urandom_range(63));
  endtask

  int radii [6] = '{20480, 8388607, 1, 0, 5000, 300000};
  int ring_set [6] = '{20, 32, 1, 0, 63, 7};
  int sector_set [6] = '{60, 64, 1, 0, 127, 13};

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // boundaries, quadrants, height extremes, every action
    send_word(ACT_ADD, 0, 0, 100, 0, 0);
    send_word(ACT_ADD, 20480, 0, 8388607, 0, 0);
    send_word(ACT_ADD, 20481, 0, 5, 0, 0);
    send_word(ACT_ADD, -20480, 0, -8388608, 0, 0);
    send_word(ACT_ADD, 0, -20480, -256, 0, 0);
    send_word(ACT_ADD, 0, 20480, -255, 0, 0);
    send_word(ACT_ADD, -100, -100, 300, 0, 0);
    send_word(ACT_ADD, -100, 100, 400, 0, 0);
    send_word(ACT_ADD, 100, -1, 500, 0, 0);
    send_word(ACT_ADD, 8388607, 8388607, 1, 0, 0);
    send_word(ACT_ADD, -8388608, -8388608, 1, 0, 0);
    send_word(ACT_ADD, 1, 0, 0, 0, 0);
    send_word(ACT_READ, 0, 0, 0, 0, 0);
    send_word(ACT_READ, 0, 0, 0, 19, 59);
    send_word(ACT_READ, 0, 0, 0, 20, 0);
    send_word(ACT_READ, 0, 0, 0, 0, 60);
    send_word(ACT_READ, 0, 0, 0, 31, 63);
    send_word(ACT_UNUSED, 5, 5, 5, 3, 3);
    send_word(ACT_CLEAR, 0, 0, 0, 0, 0);
    send_word(ACT_READ, 0, 0, 0, 19, 0);

    for (int ph = 0; ph < 6; ph++) begin
      set_grid(radii[ph], ring_set[ph], sector_set[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (ph == 1 && n % 50 == 49) wait_drained();
        random_word();
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (fails == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
